@@ src/utf8_stream_decoder_core_defines.svh @@
// Assertion macros shared by the decoder modules.
`ifndef UTF8_STREAM_DECODER_CORE_DEFINES_SVH
`define UTF8_STREAM_DECODER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check a condition in the same cycle as its trigger
`define U8D_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Check a condition in the cycle after its trigger
`define U8D_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define U8D_ASSERT_NOW(label, clk, rst, ante, cons)
`define U8D_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ src/u8d_pkg.sv @@
package u8d_pkg;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned CP_W       = 31;
   localparam int unsigned LEN_W      = 3;
   localparam int unsigned CAPACITY_W = 16;

   localparam logic [CAPACITY_W-1:0] CAPACITY_RESET = 16'hFFFF;

   // Lead and continuation byte masks
   localparam logic [BYTE_W-1:0] LEAD6_MASK      = 8'hFC;
   localparam logic [BYTE_W-1:0] LEAD5_MASK      = 8'hF8;
   localparam logic [BYTE_W-1:0] LEAD4_MASK      = 8'hF0;
   localparam logic [BYTE_W-1:0] LEAD3_MASK      = 8'hE0;
   localparam logic [BYTE_W-1:0] CONT_MASK       = 8'hC0;
   localparam logic [BYTE_W-1:0] CONT_TAG        = 8'h80;
   localparam logic [BYTE_W-1:0] ASCII_MASK      = 8'h7F;
   localparam logic [BYTE_W-1:0] CONT_VALUE_MASK = 8'h3F;

   typedef enum logic [1:0] {
      STATUS_CHAR     = 2'd0,
      STATUS_BAD_CONT = 2'd1,
      STATUS_TRUNC    = 2'd2
   } status_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              end_of_buffer;
   } req_beat_type;

   typedef struct packed {
      logic [CP_W-1:0]  code_point;
      status_type       status;
      logic [LEN_W-1:0] byte_count;
      logic             last;
   } rsp_beat_type;

   // Sequence length announced by a lead byte
   function automatic logic [LEN_W-1:0] lead_length(input logic [BYTE_W-1:0] b);
      logic [LEN_W-1:0] n;
      if (!b[7]) begin
         n = 3'd1;
      end else if ((b & LEAD6_MASK) == LEAD6_MASK) begin
         n = 3'd6;
      end else if ((b & LEAD5_MASK) == LEAD5_MASK) begin
         n = 3'd5;
      end else if ((b & LEAD4_MASK) == LEAD4_MASK) begin
         n = 3'd4;
      end else if ((b & LEAD3_MASK) == LEAD3_MASK) begin
         n = 3'd3;
      end else if ((b & CONT_MASK) == CONT_MASK) begin
         n = 3'd2;
      end else begin
         n = 3'd1;
      end
      return n;
   endfunction

endpackage

@@ src/u8d_if.sv @@
interface u8d_req_if
   import u8d_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              end_of_buffer;

   modport source (output valid, output data_byte, output end_of_buffer, input ready);
   modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface u8d_rsp_if
   import u8d_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [CP_W-1:0]  code_point;
   status_type       status;
   logic [LEN_W-1:0] byte_count;
   logic             last;

   modport source (output valid, output code_point, output status, output byte_count,
                   output last, input ready);
   modport sink   (input valid, input code_point, input status, input byte_count,
                   input last, output ready);
endinterface

@@ src/u8d_decode.sv @@
`include "utf8_stream_decoder_core_defines.svh"

module u8d_decode
   import u8d_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  req_beat_type          in_beat,
   input  logic [CAPACITY_W-1:0] capacity,
   output logic                  has_result,
   output rsp_beat_type          res
);

   logic [CP_W-1:0]       acc_ff, acc_in;
   logic [LEN_W-1:0]      remaining_ff, remaining_in;
   logic [LEN_W-1:0]      seq_len_ff, seq_len_in;
   logic [CAPACITY_W-1:0] chars_ff, chars_in;
   logic                  halted_ff, halted_in;

   logic [BYTE_W-1:0]     b;
   logic                  eob;
   logic [LEN_W-1:0]      lead_n;
   logic [BYTE_W-1:0]     lead_mask;
   logic [CAPACITY_W-1:0] chars_inc;
   status_type            kind;
   logic                  last;

   assign b   = in_beat.data_byte;
   assign eob = in_beat.end_of_buffer;

   // Decode one byte against the running sequence state
   always_comb begin
      acc_in       = acc_ff;
      remaining_in = remaining_ff;
      seq_len_in   = seq_len_ff;
      chars_in     = chars_ff;
      halted_in    = halted_ff;
      has_result   = 1'b0;
      kind         = STATUS_CHAR;
      last         = 1'b0;
      lead_n       = lead_length(b);
      lead_mask    = ASCII_MASK >> lead_n;
      chars_inc    = chars_ff + 16'd1;

      if (!halted_ff) begin
         if (remaining_ff == 3'd0) begin
            // lead byte: start a new sequence
            seq_len_in = lead_n;
            if (lead_n == 3'd1) begin
               acc_in     = {23'd0, b & ASCII_MASK};
               has_result = 1'b1;
            end else begin
               acc_in       = {23'd0, b & lead_mask};
               remaining_in = lead_n - 3'd1;
               if (eob) begin
                  has_result = 1'b1;
                  kind       = STATUS_TRUNC;
               end
            end
         end else if ((b & CONT_MASK) != CONT_TAG) begin
            has_result = 1'b1;
            kind       = STATUS_BAD_CONT;
         end else begin
            // continuation: shift six value bits in
            acc_in       = {acc_ff[CP_W-7:0], b[5:0]};
            remaining_in = remaining_ff - 3'd1;
            if (remaining_in == 3'd0) begin
               has_result = 1'b1;
            end else if (eob) begin
               has_result = 1'b1;
               kind       = STATUS_TRUNC;
            end
         end

         if (has_result) begin
            if (kind == STATUS_CHAR) begin
               chars_in = chars_inc;
               last     = eob || (chars_inc >= capacity);
            end else begin
               last = 1'b1;
            end
            if (last) begin
               halted_in    = 1'b1;
               remaining_in = 3'd0;
            end
         end
      end

      res.code_point = (kind == STATUS_CHAR) ? acc_in : '0;
      res.status     = kind;
      res.byte_count = seq_len_in;
      res.last       = last;

      // end of buffer: clear the run
      if (eob) begin
         acc_in       = '0;
         remaining_in = '0;
         seq_len_in   = '0;
         chars_in     = '0;
         halted_in    = 1'b0;
      end
   end

   // Advance sequence state on each processed beat
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         remaining_ff <= '0;
         seq_len_ff   <= '0;
         chars_ff     <= '0;
         halted_ff    <= 1'b0;
      end else if (step_en) begin
         acc_ff       <= acc_in;
         remaining_ff <= remaining_in;
         seq_len_ff   <= seq_len_in;
         chars_ff     <= chars_in;
         halted_ff    <= halted_in;
      end
   end

   `U8D_ASSERT_NOW(a_halt_no_pending, clock, reset, halted_ff, remaining_ff == 3'd0)
   `U8D_ASSERT_NOW(a_pending_in_seq, clock, reset, remaining_ff != 3'd0,
                   (seq_len_ff >= 3'd2) && (remaining_ff < seq_len_ff))
   `U8D_ASSERT_NOW(a_fault_ends_run, clock, reset,
                   step_en && has_result && (res.status != STATUS_CHAR),
                   res.last && (res.code_point == '0))

endmodule

@@ src/utf8_stream_decoder_core.sv @@
// UTF-8 stream decoder, six-byte form, 31-bit code points.
//
// req_bus carries one source byte per beat with an end-of-buffer flag.
// rsp_bus carries at most one result per byte: a code point (status 0), a bad
// continuation error (status 1) or a truncated sequence (status 2), with the
// announced byte count and a last flag on the final result of the run.
// csr_wr_en / csr_wr_data set the destination capacity (characters per run);
// write it only while no beats are in flight.
//
// An accepted byte passes through the input register, then through the decode
// logic into the result register, and is shown on rsp_bus from there. Throughput
// is one byte per cycle while rsp_bus is not stalled, set by the single decode stage
// sitting between those two registers.
// A stalled rsp_bus holds its result; one more byte waits in the input
// register, then req_bus.ready drops until the result is taken. Bytes that
// produce no result drain as soon as the result register has room.
// Reset clears all run state and sets the capacity to 65535.
`include "utf8_stream_decoder_core_defines.svh"

module utf8_stream_decoder_core
   import u8d_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   u8d_req_if.sink               req_bus,
   u8d_rsp_if.source             rsp_bus,
   input  logic                  csr_wr_en,
   input  logic [CAPACITY_W-1:0] csr_wr_data
);

   logic [CAPACITY_W-1:0] capacity_ff;
   logic                  in_valid_ff;
   req_beat_type          in_beat_ff;
   logic                  rsp_valid_ff;
   rsp_beat_type          rsp_beat_ff;

   logic                  advance;
   logic                  dec_has_result;
   rsp_beat_type          dec_res;

   // Process the held beat when the result register has room
   assign advance       = in_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;

   // Capacity register
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else if (csr_wr_en) begin
         capacity_ff <= csr_wr_data;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_beat_ff.data_byte     <= req_bus.data_byte;
         in_beat_ff.end_of_buffer <= req_bus.end_of_buffer;
      end
   end

   u8d_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .step_en    (advance),
      .in_beat    (in_beat_ff),
      .capacity   (capacity_ff),
      .has_result (dec_has_result),
      .res        (dec_res)
   );

   // Result register: load on a result, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && dec_has_result) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && dec_has_result) begin
         rsp_beat_ff <= dec_res;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.code_point = rsp_beat_ff.code_point;
   assign rsp_bus.status     = rsp_beat_ff.status;
   assign rsp_bus.byte_count = rsp_beat_ff.byte_count;
   assign rsp_bus.last       = rsp_beat_ff.last;

   `U8D_ASSERT_NOW(a_stall_blocks_input, clock, reset,
                   in_valid_ff && rsp_valid_ff && !rsp_bus.ready, !req_bus.ready)
   `U8D_ASSERT_NOW(a_trunc_is_last, clock, reset,
                   rsp_valid_ff && (rsp_beat_ff.status == STATUS_TRUNC), rsp_beat_ff.last)
   `U8D_ASSERT_NOW(a_eob_result_last, clock, reset,
                   advance && in_beat_ff.end_of_buffer && dec_has_result, dec_res.last)

endmodule

@@ dv/tb.sv @@
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import u8d_pkg::*;

   localparam int CYCLE_LIMIT   = 600000;
   localparam int HOLD_CYCLES   = 200;
   localparam int SETTLE_CYCLES = 6;
   localparam int RANDOM_BYTES  = 750;
   localparam int ROUND_BYTES   = 60;
   localparam int REPORT_LIMIT  = 10;

   // Tracks the decoder state and holds the results still owed by the block
   class decode_scoreboard;
      logic [CP_W-1:0]       accum;
      logic [LEN_W-1:0]      remaining;
      logic [LEN_W-1:0]      seq_len;
      logic [CAPACITY_W-1:0] emitted;
      logic [CAPACITY_W-1:0] capacity;
      bit                    halted;
      rsp_beat_type          expected_chars[$];
      int                    errors;
      int                    live_bytes;

      function new();
         clear_run();
         capacity   = CAPACITY_RESET;
         errors     = 0;
         live_bytes = 0;
      endfunction

      function void clear_run();
         accum     = '0;
         remaining = '0;
         seq_len   = '0;
         emitted   = '0;
         halted    = 1'b0;
      endfunction

      function logic [LEN_W-1:0] announced_length(logic [7:0] b);
         logic [LEN_W-1:0] n;
         casez (b)
            8'b0???_????: n = 3'd1;
            8'b10??_????: n = 3'd1;
            8'b110?_????: n = 3'd2;
            8'b1110_????: n = 3'd3;
            8'b1111_0???: n = 3'd4;
            8'b1111_10??: n = 3'd5;
            default:      n = 3'd6;
         endcase
         return n;
      endfunction

      function void report(string msg);
         errors++;
         if (errors <= REPORT_LIMIT) $display("ERROR: %s", msg);
      endfunction

      // Advance the state by one accepted byte and note any result it owes
      function void take_byte(logic [7:0] b, logic eob);
         logic [LEN_W-1:0] n;
         bit               owes;
         status_type       st;
         rsp_beat_type     item;

         owes = 1'b0;
         st   = STATUS_CHAR;
         live_bytes++;
         if (halted) begin
            if (eob) clear_run();
            return;
         end

         if (remaining == 0) begin
            n       = announced_length(b);
            seq_len = n;
            if (n == 3'd1) begin
               accum = 31'(b & 8'h7f);
               owes  = 1'b1;
            end else begin
               accum     = 31'(b & (8'h7f >> n));
               remaining = n - 3'd1;
               if (eob) begin
                  owes = 1'b1;
                  st   = STATUS_TRUNC;
               end
            end
         end else if (b[7:6] != 2'b10) begin
            owes = 1'b1;
            st   = STATUS_BAD_CONT;
         end else begin
            accum     = {accum[CP_W-7:0], b[5:0]};
            remaining = remaining - 3'd1;
            if (remaining == 0) begin
               owes = 1'b1;
            end else if (eob) begin
               owes = 1'b1;
               st   = STATUS_TRUNC;
            end
         end

         if (!owes) begin
            if (eob) clear_run();
            return;
         end

         item.status     = st;
         item.byte_count = seq_len;
         if (st == STATUS_CHAR) begin
            emitted         = emitted + 1'b1;
            item.last       = eob || (emitted >= capacity);
            item.code_point = accum;
         end else begin
            item.last       = 1'b1;
            item.code_point = '0;
         end
         expected_chars.push_back(item);

         if (eob) begin
            clear_run();
         end else if (item.last) begin
            halted    = 1'b1;
            remaining = '0;
         end
      endfunction

      // Compare one accepted result beat with the oldest owed result
      function void check_char(rsp_beat_type got);
         rsp_beat_type want;
         if (expected_chars.size() == 0) begin
            report($sformatf("result with nothing owed: cp %h status %0d count %0d last %0d",
                             got.code_point, got.status, got.byte_count, got.last));
            return;
         end
         want = expected_chars.pop_front();
         if (got.code_point !== want.code_point)
            report($sformatf("code_point: expected %h, got %h", want.code_point, got.code_point));
         if (got.status !== want.status)
            report($sformatf("status: expected %0d, got %0d", want.status, got.status));
         if (got.byte_count !== want.byte_count)
            report($sformatf("byte_count: expected %0d, got %0d", want.byte_count, got.byte_count));
         if (got.last !== want.last)
            report($sformatf("last: expected %0d, got %0d", want.last, got.last));
      endfunction
   endclass

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  csr_wr_en = 1'b0;
   logic [CAPACITY_W-1:0] csr_wr_data = '0;
   logic                  req_busy = 1'b0;
   logic                  idle_on = 1'b0;
   logic                  rsp_hold = 1'b0;
   logic                  pressure_go = 1'b0;
   int                    cycle_count = 0;
   req_beat_type          pending_bytes[$];
   logic [7:0]            buffer_bytes[$];
   decode_scoreboard      sb;

   u8d_req_if req_bus ();
   u8d_rsp_if rsp_bus ();

   utf8_stream_decoder_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Mostly short stalls, a few long ones
   function automatic int stall_length();
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic void queue_byte(logic [7:0] b, logic eob);
      req_beat_type beat;
      beat.data_byte     = b;
      beat.end_of_buffer = eob;
      pending_bytes.push_back(beat);
   endfunction

   function automatic logic [7:0] lead_byte(int len);
      case (len)
         1:       return 8'($urandom_range(0, 127));
         2:       return 8'hc0 | 8'($urandom_range(0, 31));
         3:       return 8'he0 | 8'($urandom_range(0, 15));
         4:       return 8'hf0 | 8'($urandom_range(0, 7));
         5:       return 8'hf8 | 8'($urandom_range(0, 3));
         default: return 8'hfc | 8'($urandom_range(0, 3));
      endcase
   endfunction

   // Append a lead of the given length and keep only the first kept bytes
   function automatic void append_sequence(int len, int kept);
      buffer_bytes.push_back(lead_byte(len));
      for (int i = 1; i < kept; i++) buffer_bytes.push_back(8'h80 | 8'($urandom_range(0, 63)));
   endfunction

   // Build one source buffer: mostly well-formed characters, some noise and broken ones
   function automatic void queue_buffer();
      int   n_chars;
      int   pick;
      int   len;
      logic eob_at_end;
      buffer_bytes.delete();
      n_chars = $urandom_range(1, 10);
      for (int c = 0; c < n_chars; c++) begin
         pick = $urandom_range(0, 99);
         len  = $urandom_range(1, 6);
         if (pick < 72) begin
            append_sequence(len, len);
         end else if (pick < 86) begin
            buffer_bytes.push_back(8'($urandom_range(0, 255)));
         end else begin
            // short sequence followed by a byte that is not a continuation
            len = $urandom_range(2, 6);
            append_sequence(len, $urandom_range(1, len - 1));
            pick = $urandom_range(0, 191);
            buffer_bytes.push_back(pick < 128 ? 8'(pick) : 8'(pick + 64));
         end
      end
      // cut the closing sequence off at the buffer end
      if ($urandom_range(0, 4) == 0) begin
         len = $urandom_range(2, 6);
         append_sequence(len, $urandom_range(1, len - 1));
      end
      eob_at_end = ($urandom_range(0, 9) != 0);
      for (int i = 0; i < buffer_bytes.size(); i++)
         queue_byte(buffer_bytes[i], eob_at_end && (i == buffer_bytes.size() - 1));
   endfunction

   // Hold each byte beat until accepted, then idle for a random gap
   initial begin : byte_sender
      req_beat_type beat;
      int           gap_left;
      req_bus.valid         = 1'b0;
      req_bus.data_byte     = '0;
      req_bus.end_of_buffer = 1'b0;
      gap_left              = 0;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         if (!req_busy) begin
            if (gap_left == 0 && pending_bytes.size() != 0) begin
               beat = pending_bytes.pop_front();
               req_bus.valid         <= 1'b1;
               req_bus.data_byte     <= beat.data_byte;
               req_bus.end_of_buffer <= beat.end_of_buffer;
               req_busy = 1'b1;
            end else begin
               if (gap_left > 0) gap_left--;
               req_bus.valid <= 1'b0;
            end
         end
         @(posedge clock);
         if (req_busy && req_bus.ready === 1'b1) begin
            sb.take_byte(beat.data_byte, beat.end_of_buffer);
            req_busy = 1'b0;
            gap_left = (idle_on && $urandom_range(0, 3) == 0) ? stall_length() : 0;
         end
      end
   end

   // Drop ready at random, take result beats and check them
   initial begin : char_sink
      rsp_beat_type got;
      int           stall_left;
      rsp_bus.ready = 1'b0;
      stall_left    = 0;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         if (rsp_hold) begin
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            stall_left = stall_length() - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
         @(posedge clock);
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            got.code_point = rsp_bus.code_point;
            got.status     = rsp_bus.status;
            got.byte_count = rsp_bus.byte_count;
            got.last       = rsp_bus.last;
            sb.check_char(got);
         end
      end
   end

   // Hold off the result side for a long stretch so the block backs up
   initial begin : rsp_hold_off
      wait (pressure_go === 1'b1);
      @(posedge clock);
      rsp_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold = 1'b0;
   end

   task automatic wait_idle();
      while (pending_bytes.size() != 0 || req_busy || sb.expected_chars.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_capacity(logic [CAPACITY_W-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      sb.capacity = value;
   endtask

   initial begin : main_seq
      int                    live_base;
      int                    round;
      logic [CAPACITY_W-1:0] cap;
      sb = new();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Lead lengths 1, 2, 5 and 6, stray continuation, byte extremes, end mark on a full char
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h7f, 1'b0);
      queue_byte(8'h80, 1'b0);
      queue_byte(8'hdf, 1'b0);
      queue_byte(8'hbf, 1'b0);
      queue_byte(8'hfb, 1'b0);
      repeat (4) queue_byte(8'h80, 1'b0);
      queue_byte(8'hff, 1'b0);
      repeat (4) queue_byte(8'hbf, 1'b0);
      queue_byte(8'hbf, 1'b1);
      wait_idle();

      // Bad continuation, halted bytes, clear on end mark, truncation at lead and mid-sequence
      idle_on = 1'b1;
      queue_byte(8'hc3, 1'b0);
      queue_byte(8'h41, 1'b0);
      queue_byte(8'h00, 1'b1);
      queue_byte(8'hc3, 1'b1);
      queue_byte(8'he2, 1'b0);
      queue_byte(8'h82, 1'b1);
      wait_idle();

      // Capacity reached, then drop until the end mark
      write_capacity(16'd2);
      queue_byte(8'h41, 1'b0);
      queue_byte(8'h42, 1'b0);
      queue_byte(8'h43, 1'b1);
      wait_idle();

      // Lower the capacity below the count in the middle of a run
      write_capacity(16'd3);
      queue_byte(8'h41, 1'b0);
      queue_byte(8'h42, 1'b0);
      wait_idle();
      write_capacity(16'd1);
      queue_byte(8'h43, 1'b0);
      queue_byte(8'h0a, 1'b1);
      wait_idle();

      // Random buffers over a sweep of capacities
      live_base = sb.live_bytes;
      round     = 0;
      while (sb.live_bytes - live_base < RANDOM_BYTES) begin
         case (round % 6)
            0:       cap = CAPACITY_RESET;
            1:       cap = 16'($urandom_range(1, 4));
            2:       cap = 16'($urandom_range(1, 65535));
            3:       cap = 16'd1;
            4:       cap = 16'($urandom_range(5, 30));
            default: cap = 16'($urandom_range(100, 65534));
         endcase
         write_capacity(cap);
         idle_on = ($urandom_range(0, 3) != 0);
         while (pending_bytes.size() < ROUND_BYTES) queue_buffer();
         if (round == 2) pressure_go = 1'b1;
         wait_idle();
         round++;
      end

      repeat (SETTLE_CYCLES) @(negedge clock);
      if (sb.expected_chars.size() != 0)
         sb.report($sformatf("%0d results never arrived", sb.expected_chars.size()));
      if (sb.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
